@@ design/imh_pkg.sv @@
`default_nettype none
package imh_pkg;
  localparam int CAPACITY = 256;
  localparam int DEPTH = 256;
  localparam int CAP_EFF = (CAPACITY < DEPTH) ? CAPACITY : DEPTH;
  localparam int AW = 8;
  localparam int KW = 32;
  localparam int IW = 8;
  localparam int CW = 9;
  localparam int EW = KW + IW;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_POP = 2'd1;
  localparam logic [1:0] REQ_DEC = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_WAIT, S_ITEM_RD, S_ITEM_WAIT, S_KEY_WAIT,
    S_UP_RD, S_UP_WAIT, S_DN_RD, S_DN_WAIT, S_DN_RD2, S_DN_WAIT2,
    S_FIN_RD, S_FIN_WAIT, S_DONE
  } state_t;

  function automatic logic key_less(input logic [KW-1:0] a, input logic [KW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction
endpackage
`default_nettype wire

@@ design/imh_ram.sv @@
`default_nettype none
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AWIDTH = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AWIDTH-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [AWIDTH-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/indexed_min_heap.sv @@
// done is the result strobe; load and decrease-key sift the item up toward the root and pop
// sifts the last entry down from the root, one level per step; a rejected request, a query or
// a decrease-key that is not lower moves nothing, nor does a pop that empties the heap
// busy drops in the done cycle, so the next request can be accepted at its end
// throughput is set by the one-read-port slot memory walked one level per step; no stall
// synchronous reset empties the heap and clears the per-item present flags
`default_nettype none
module indexed_min_heap import imh_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    req_type,
  input  wire logic [7:0]    item,
  input  wire logic [31:0]   priority_req,
  output logic               done,
  output logic [1:0]         status,
  output logic [7:0]         min_item,
  output logic [31:0]        min_priority,
  output logic [8:0]         heap_size,
  output logic               item_present,
  output logic [31:0]        item_priority,
  output logic [7:0]         popped_item
);
  state_t state, state_next;

  // slot memory: {key, item}; item memory: slot per item
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [EW-1:0] s_wd, s_rd;
  logic          p_we;
  logic [AW-1:0] p_wa, p_ra;
  logic [AW-1:0] p_wd, p_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  imh_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic [DEPTH-1:0] present;
  logic [CW-1:0]    count, loaded;
  logic [1:0]       req;
  logic [IW-1:0]    r_item;
  logic [KW-1:0]    r_pri;
  logic [AW-1:0]    pos;
  logic [KW-1:0]    cur_key;
  logic [IW-1:0]    cur_item;
  logic [EW-1:0]    cand;
  logic [CW:0]      cand_pos;
  logic [1:0]       st;
  logic             pres_o;
  logic [KW-1:0]    ipri_o;
  logic [IW-1:0]    pop_o;
  logic [EW-1:0]    root;

  logic [AW-1:0] parent;
  logic [CW:0]   left;
  assign parent = (pos - AW'(1)) >> 1;
  assign left = {1'b0, pos, 1'b1};
  logic dn_has_l, dn_has_r;
  assign dn_has_l = left < (CW+1)'(count);
  assign dn_has_r = (left + (CW+1)'(1)) < (CW+1)'(count);

  // a full load reports no item even if the offered number is in the heap
  logic item_hit;
  assign item_hit = (req != REQ_POP) && (st != ST_FULL) && present[r_item];

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    s_we = 1'b0; s_wa = pos; s_wd = {cur_key, cur_item}; s_ra = pos;
    p_we = 1'b0; p_wa = cur_item; p_wd = pos; p_ra = r_item;
    unique case (state)
      S_IDLE: if (start) begin
        unique case (req_type)
          REQ_LOAD: state_next = (loaded >= CW'(CAP_EFF)) ? S_FIN_RD : S_UP_RD;
          REQ_POP:  state_next = (count == '0) ? S_FIN_RD : S_POP_RD;
          default:  state_next = present[item] ? S_ITEM_RD : S_FIN_RD;
        endcase
      end
      S_POP_RD: begin
        s_ra = AW'(count);
        state_next = S_POP_WAIT;
      end
      S_POP_WAIT: state_next = (count == '0) ? S_FIN_RD : S_DN_RD;
      S_ITEM_RD: begin
        p_ra = r_item;
        state_next = S_ITEM_WAIT;
      end
      S_ITEM_WAIT: begin
        s_ra = p_rd;
        state_next = S_KEY_WAIT;
      end
      S_KEY_WAIT: state_next = (req == REQ_DEC && key_less(r_pri, s_rd[EW-1:IW]))
                               ? S_UP_RD : S_FIN_RD;
      S_UP_RD: begin
        if (pos == '0) begin
          s_we = 1'b1; p_we = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          s_ra = parent;
          state_next = S_UP_WAIT;
        end
      end
      S_UP_WAIT: begin
        if (key_less(cur_key, s_rd[EW-1:IW])) begin
          // parent moves down into the hole
          s_we = 1'b1; s_wd = s_rd;
          p_we = 1'b1; p_wa = s_rd[IW-1:0];
          state_next = S_UP_RD;
        end else begin
          s_we = 1'b1; p_we = 1'b1;
          state_next = S_FIN_RD;
        end
      end
      S_DN_RD: begin
        if (!dn_has_l) begin
          s_we = 1'b1; p_we = 1'b1;
          state_next = S_FIN_RD;
        end else begin
          s_ra = left[AW-1:0];
          state_next = S_DN_WAIT;
        end
      end
      S_DN_WAIT: begin
        if (dn_has_r) begin
          s_ra = AW'(left + (CW+1)'(1));
          state_next = S_DN_WAIT2;
        end else state_next = S_DN_RD2;
      end
      S_DN_WAIT2: state_next = S_DN_RD2;
      S_DN_RD2: begin
        if (key_less(cand[EW-1:IW], cur_key)) begin
          s_we = 1'b1; s_wd = cand;
          p_we = 1'b1; p_wa = cand[IW-1:0];
          state_next = S_DN_RD;
        end else begin
          s_we = 1'b1; p_we = 1'b1;
          state_next = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        s_ra = '0;
        p_ra = r_item;
        state_next = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        s_ra = p_rd;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // candidate child for sift-down: left first, right only on strict less
  logic [EW-1:0] cand_sel;
  always_comb begin
    cand_sel = cand;
    if (state == S_DN_WAIT) cand_sel = s_rd;
    else if (state == S_DN_WAIT2 && key_less(s_rd[EW-1:IW], cand[EW-1:IW])) cand_sel = s_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      present <= '0;
      count <= '0;
      loaded <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          req <= req_type; r_item <= item; r_pri <= priority_req;
          st <= ST_OK; pres_o <= 1'b0; ipri_o <= '0; pop_o <= '0;
          unique case (req_type)
            REQ_LOAD: if (loaded >= CW'(CAP_EFF)) st <= ST_FULL;
              else begin
                pos <= AW'(count); cur_key <= priority_req; cur_item <= loaded[IW-1:0];
                r_item <= loaded[IW-1:0];
                present[loaded[IW-1:0]] <= 1'b1;
                count <= count + CW'(1); loaded <= loaded + CW'(1);
              end
            REQ_POP: if (count == '0) st <= ST_EMPTY;
              else count <= count - CW'(1);
            default: if (!present[item]) st <= ST_ABSENT;
          endcase
        end
        S_POP_RD: begin
          pop_o <= root[IW-1:0];
          present[root[IW-1:0]] <= 1'b0;
          r_item <= root[IW-1:0];
        end
        S_POP_WAIT: begin
          pos <= '0; cur_key <= s_rd[EW-1:IW]; cur_item <= s_rd[IW-1:0];
        end
        S_ITEM_WAIT: pos <= p_rd;
        S_KEY_WAIT: if (req == REQ_DEC) begin
          if (key_less(r_pri, s_rd[EW-1:IW])) begin
            cur_key <= r_pri; cur_item <= s_rd[IW-1:0];
          end else st <= ST_ABSENT;
        end
        S_UP_WAIT: if (key_less(cur_key, s_rd[EW-1:IW])) pos <= parent;
        S_DN_WAIT, S_DN_WAIT2: begin
          cand <= cand_sel;
          if (state == S_DN_WAIT) cand_pos <= left;
          else if (cand_sel == s_rd && key_less(s_rd[EW-1:IW], cand[EW-1:IW]))
            cand_pos <= left + (CW+1)'(1);
        end
        S_DN_RD2: if (key_less(cand[EW-1:IW], cur_key)) pos <= cand_pos[AW-1:0];
        S_DONE: done <= 1'b1;
        default: ;
      endcase
      // root tracked in flops to avoid an extra read for pop
      if (s_we && s_wa == '0) root <= s_wd;
      // the item's key after the request is on the read port during S_DONE
      if (state == S_DONE) begin
        pres_o <= item_hit;
        ipri_o <= item_hit ? s_rd[EW-1:IW] : '0;
      end
    end
  end

  assign status = st;
  assign min_item = (count != '0) ? root[IW-1:0] : '0;
  assign min_priority = (count != '0) ? root[EW-1:IW] : '0;
  assign heap_size = count;
  assign item_present = pres_o;
  assign item_priority = ipri_o;
  assign popped_item = pop_o;
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
  import imh_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [7:0]  item;
  logic [31:0] priority_req;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  min_item;
  logic [31:0] min_priority;
  logic [8:0]  heap_size;
  logic        item_present;
  logic [31:0] item_priority;
  logic [7:0]  popped_item;

  indexed_min_heap DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .item(item), .priority_req(priority_req),
    .done(done), .status(status), .min_item(min_item),
    .min_priority(min_priority), .heap_size(heap_size),
    .item_present(item_present), .item_priority(item_priority),
    .popped_item(popped_item)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  min_item;
    logic [31:0] min_priority;
    logic [8:0]  heap_size;
    logic        item_present;
    logic [31:0] item_priority;
    logic [7:0]  popped_item;
  } answer_t;

  typedef struct {
    logic [1:0]  req;
    logic [7:0]  itm;
    logic [31:0] pri;
    bit          typed;
    logic [1:0]  st;
    logic [8:0]  size;
  } row_t;

  // shadow heap
  logic [31:0] sh_key [256];
  logic [7:0]  sh_item [256];
  logic [7:0]  sh_slot [256];
  bit          sh_in [256];
  int          sh_count;
  int          sh_loaded;

  answer_t answer_q[$];
  int      errors;
  bit      quiet;

  function automatic bit lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [31:0] k;
    logic [7:0]  it;
    k = sh_key[a]; it = sh_item[a];
    sh_key[a] = sh_key[b]; sh_item[a] = sh_item[b];
    sh_key[b] = k; sh_item[b] = it;
    sh_slot[sh_item[a]] = a[7:0];
    sh_slot[sh_item[b]] = b[7:0];
  endfunction

  function automatic void bubble_up(int pos);
    int p;
    while (pos > 0) begin
      p = (pos - 1) / 2;
      if (!lt(sh_key[pos], sh_key[p])) break;
      swap_entries(pos, p);
      pos = p;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int l, r, best;
    forever begin
      l = 2 * pos + 1; r = l + 1; best = pos;
      if (l < sh_count && lt(sh_key[l], sh_key[best])) best = l;
      if (r < sh_count && lt(sh_key[r], sh_key[best])) best = r;
      if (best == pos) break;
      swap_entries(pos, best);
      pos = best;
    end
  endfunction

  function automatic answer_t heap_apply(logic [1:0] rq, logic [7:0] it, logic [31:0] pr);
    answer_t a;
    int s;
    a = '0;
    if (rq == REQ_LOAD) begin
      if (sh_loaded >= CAP_EFF) a.status = ST_FULL;
      else begin
        s = sh_count;
        it = sh_loaded[7:0];
        sh_key[s] = pr; sh_item[s] = it; sh_slot[it] = s[7:0]; sh_in[it] = 1;
        sh_count++; sh_loaded++;
        bubble_up(s);
        a.item_present = 1; a.item_priority = pr;
      end
    end else if (rq == REQ_POP) begin
      if (sh_count == 0) a.status = ST_EMPTY;
      else begin
        a.popped_item = sh_item[0];
        sh_in[sh_item[0]] = 0;
        sh_key[0] = sh_key[sh_count-1]; sh_item[0] = sh_item[sh_count-1];
        sh_count--;
        if (sh_count > 0) begin
          sh_slot[sh_item[0]] = 0;
          bubble_down(0);
        end
      end
    end else begin
      if (!sh_in[it]) a.status = ST_ABSENT;
      else begin
        a.item_present = 1;
        if (rq == REQ_DEC) begin
          if (lt(pr, sh_key[sh_slot[it]])) begin
            sh_key[sh_slot[it]] = pr;
            bubble_up(sh_slot[it]);
          end else a.status = ST_ABSENT;
        end
        a.item_priority = sh_key[sh_slot[it]];
      end
    end
    if (sh_count > 0) begin
      a.min_item = sh_item[0]; a.min_priority = sh_key[0];
    end
    a.heap_size = sh_count[8:0];
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (answer_q.size() == 0) report("unexpected result", 0, 0);
      else begin
        w = answer_q.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (min_item !== w.min_item) report("min_item", min_item, w.min_item);
        if (min_priority !== w.min_priority)
          report("min_priority", min_priority, w.min_priority);
        if (heap_size !== w.heap_size) report("heap_size", heap_size, w.heap_size);
        if (item_present !== w.item_present)
          report("item_present", item_present, w.item_present);
        if (item_priority !== w.item_priority)
          report("item_priority", item_priority, w.item_priority);
        if (popped_item !== w.popped_item)
          report("popped_item", popped_item, w.popped_item);
      end
    end
  end

  task automatic send(logic [1:0] rq, logic [7:0] it, logic [31:0] pr);
    answer_t a;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(posedge clk);
    start <= 1; req_type <= rq; item <= it; priority_req <= pr;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = heap_apply(rq, it, pr);
    answer_q.push_back(a);
    start <= 0;
    // wait for this request to finish before the next is offered
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pri();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_item();
    int tries;
    logic [7:0] c;
    for (tries = 0; tries < 8; tries++) begin
      c = $urandom_range(0, 255);
      if (sh_in[c]) return c;
    end
    if (sh_count > 0) return sh_item[$urandom_range(0, sh_count - 1)];
    return $urandom;
  endfunction

  row_t rows[$];

  task automatic add_row(logic [1:0] rq, logic [7:0] it, logic [31:0] pr,
                         bit ty = 0, logic [1:0] st = ST_OK, logic [8:0] sz = 0);
    row_t r;
    r.req = rq; r.itm = it; r.pri = pr; r.typed = ty; r.st = st; r.size = sz;
    rows.push_back(r);
  endtask

  initial begin
    int n, phase;
    logic [31:0] cur;
    logic [7:0] it;
    answer_t a;
    errors = 0; quiet = 0;
    rst = 1; start = 0; req_type = REQ_LOAD; item = 0; priority_req = 0;
    sh_count = 0; sh_loaded = 0;
    foreach (sh_in[i]) sh_in[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_row(REQ_POP,   8'd0,   32'd0,        1, ST_EMPTY,  9'd0);
    add_row(REQ_QUERY, 8'd0,   32'd0,        1, ST_ABSENT, 9'd0);
    add_row(REQ_DEC,   8'hff,  32'h8000_0000, 1, ST_ABSENT, 9'd0);
    add_row(REQ_LOAD,  8'hff,  32'h7fff_ffff, 1, ST_OK,     9'd1);
    add_row(REQ_LOAD,  8'd0,   32'h8000_0000, 1, ST_OK,     9'd2);
    add_row(REQ_LOAD,  8'd0,   32'h0001_0000);
    add_row(REQ_LOAD,  8'd0,   32'h0001_0000);
    add_row(REQ_LOAD,  8'd0,   32'hffff_0000);
    add_row(REQ_DEC,   8'd2,   32'h0001_0000);
    add_row(REQ_DEC,   8'd2,   32'h0002_0000);
    add_row(REQ_DEC,   8'd0,   32'h8000_0001);
    add_row(REQ_DEC,   8'd3,   32'h8000_0000);
    add_row(REQ_QUERY, 8'd3,   32'hffff_ffff);
    add_row(REQ_QUERY, 8'd9,   32'd0,        1, ST_ABSENT, 9'd5);
    add_row(REQ_POP,   8'd0,   32'd0);
    add_row(REQ_POP,   8'd0,   32'd0);
    add_row(REQ_QUERY, 8'd1,   32'd0);
    add_row(REQ_POP,   8'd0,   32'd0);
    add_row(REQ_POP,   8'd0,   32'd0);
    add_row(REQ_POP,   8'd0,   32'd0,        1, ST_OK,     9'd0);
    add_row(REQ_POP,   8'd0,   32'd0,        1, ST_EMPTY,  9'd0);

    foreach (rows[i]) begin
      send(rows[i].req, rows[i].itm, rows[i].pri);
      if (rows[i].typed) begin
        a = answer_q[$];
        if (a.status !== rows[i].st || a.heap_size !== rows[i].size)
          report("directed row", 32'({a.status, a.heap_size}),
                 32'({rows[i].st, rows[i].size}));
      end
    end

    // random: fill toward capacity, mix decrease/query/pop, then hit full and drain
    for (n = 0; n < 1100; n++) begin
      if (n > 1000) quiet = 1;
      phase = $urandom_range(0, 99);
      if (phase < 40) send(REQ_LOAD, $urandom, rand_pri());
      else if (phase < 60) send(REQ_POP, $urandom, $urandom);
      else if (phase < 85) begin
        it = pick_item();
        cur = sh_in[it] ? sh_key[sh_slot[it]] : 0;
        if (sh_in[it] && $urandom_range(0, 3) != 0 && cur != 32'h8000_0000)
          send(REQ_DEC, it, cur - $urandom_range(1, 1000));
        else send(REQ_DEC, it, rand_pri());
      end else begin
        it = ($urandom_range(0, 4) == 0) ? $urandom : pick_item();
        send(REQ_QUERY, it, $urandom);
      end
    end
    // reach the load limit
    while (sh_loaded < CAP_EFF) send(REQ_LOAD, $urandom, rand_pri());
    send(REQ_LOAD, 8'd0, 32'd5);
    while (sh_count > 0) send(REQ_POP, 0, 0);
    send(REQ_POP, 0, 0);

    n = 0;
    while (answer_q.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    repeat (30) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end
endmodule
